// ===== hw/rtl/pareto_rank_crowding_defines.svh =====
// ----------------------------------------------------------------------------
// Pareto rank and crowding - assertion macros
// Shared helpers for concurrent checks, clocked on clk, quiet under reset.
// ----------------------------------------------------------------------------
`ifndef PARETO_RANK_CROWDING_DEFINES_SVH
`define PARETO_RANK_CROWDING_DEFINES_SVH

// Same-cycle implication, disabled while rst_n is low
`define PRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication, disabled while rst_n is low
`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Types and constants shared by the Pareto rank and crowding block.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int IX_W   = 6;   // point index width on the ports
  localparam int LV_W   = 7;   // front number width
  localparam int OBJ_W  = 32;  // objective width, Q16.16
  localparam int DIST_W = 16;  // crowding distance width, Q8.8
  localparam int Q_W    = 9;   // normalised gap quotient, 0..256

  localparam logic [DIST_W-1:0] HUNDRED  = 16'd25600;  // 100.0 in Q8.8
  localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

  typedef struct packed {
    logic signed [OBJ_W-1:0] time_delta;
    logic signed [OBJ_W-1:0] memory_delta;
    logic                    last_point;
  } in_item_t;

  typedef struct packed {
    logic [IX_W-1:0]   point_index;
    logic [LV_W-1:0]   pareto_level;
    logic [DIST_W-1:0] crowd_distance;
    logic              dropped_points;
    logic              last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RK_I_RD,
    S_RK_I_LAT,
    S_RK_J_RD,
    S_RK_J_EV,
    S_RK_ASSIGN,
    S_RK_END,
    S_CR_P_RD,
    S_CR_P_LAT,
    S_CR_J_RD,
    S_CR_J_EV,
    S_TDIV,
    S_TDIV_W,
    S_MDIV,
    S_MDIV_W,
    S_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            wr_en;       // store incoming point
    logic [IX_W-1:0] wr_addr;
    logic [IX_W-1:0] rd_addr;     // store read address (registered read)
    logic [IX_W-1:0] p_idx;       // point under evaluation
    logic            clr_run;     // clear front bookkeeping for a new run
    logic            latch_p;     // capture point p from read data
    logic            rank_eval;   // dominance check of j against p
    logic            assign_lvl;  // write front number of p
    logic [LV_W-1:0] level;
    logic            end_pass;    // fold this pass's front into the done set
    logic            crowd_eval;  // neighbour search step
    logic            div_start;
    logic            div_sel;     // 0: time gap, 1: memory gap
    logic            take_t;      // keep time contribution
    logic            emit;        // load output register
    logic            dropped;
    logic            last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done_p;    // point p already has a front
    logic blocked;   // p has a dominator still unranked
    logic div_busy;
    logic out_full;
  } sts_t;

endpackage

// ===== hw/rtl/pareto_rank_crowding.sv =====
// ----------------------------------------------------------------------------
// pareto_rank_crowding
// Non-dominated sorting and crowding distance over a two-objective population.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on in_valid/in_ready, one request a cycle while loading.
//   Up to POP_SIZE points are held; later ones are dropped and flagged.
//   The request with last_point set closes the population and starts ranking;
//   in_ready stays low until the final result of the run has been produced.
//   Ranking peels one front per pass over the n held points: each point still
//   unranked is read, latched and checked against every held point, each point
//   already ranked is skipped, and the pass ends by folding its front in.
//   Each result then takes a scan of the store plus two divisions in the
//   shared divider and a step to emit.
//   Results leave on out_valid/out_ready in load order; the last one carries
//   last_result. The result register lets the next point be worked on while
//   a result waits; a stalled receiver holds the block once the next result
//   is ready. Reset (rst_n low, synchronous) empties the population.
// ----------------------------------------------------------------------------
module pareto_rank_crowding #(
  parameter int POP_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  prc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output prc_pkg::out_item_t out_data
);

  prc_pkg::cmd_t cmd;
  prc_pkg::sts_t sts;

  prc_ctrl #(.POP_SIZE(POP_SIZE)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_point),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prc_dp #(.POP_SIZE(POP_SIZE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/prc_div.sv =====
// ----------------------------------------------------------------------------
// prc_div
// Restoring divider: floor(256 * gap / range) for gap <= range, one bit a cycle.
// ----------------------------------------------------------------------------
module prc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [prc_pkg::OBJ_W-1:0]        gap,
  input  logic [prc_pkg::OBJ_W-1:0]        range,
  output logic                             busy,
  output logic [prc_pkg::Q_W-1:0]          quot
);

  logic [prc_pkg::OBJ_W-1:0] rem_r, rem_nxt;
  logic [prc_pkg::OBJ_W-1:0] dvs_r;
  logic [prc_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic [prc_pkg::OBJ_W:0]   rem2;
  logic                      bit_hi;

  assign bit_hi = gap >= range;
  assign rem2   = {rem_r, 1'b0};

  // one quotient bit per step
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = bit_hi ? (gap - range) : gap;
      q_nxt   = {{(prc_pkg::Q_W-1){1'b0}}, bit_hi};
      cnt_nxt = 4'd8;
    end else if (cnt_r != 4'd0) begin
      if (rem2 >= {1'b0, dvs_r}) begin
        rem_nxt = prc_pkg::OBJ_W'(rem2 - {1'b0, dvs_r});
        q_nxt   = {q_r[prc_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem2[prc_pkg::OBJ_W-1:0];
        q_nxt   = {q_r[prc_pkg::Q_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      dvs_r <= range;
    end
  end

  assign busy = cnt_r != 4'd0;
  assign quot = q_r;

endmodule

// ===== hw/rtl/prc_dp.sv =====
// ----------------------------------------------------------------------------
// prc_dp
// Datapath: point stores, front bookkeeping, neighbour search and result reg.
// ----------------------------------------------------------------------------
module prc_dp #(
  parameter int POP_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  prc_pkg::in_item_t  in_data,
  input  prc_pkg::cmd_t      cmd,
  output prc_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_ready,
  output prc_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(POP_SIZE);

  // point stores and front numbers
  logic signed [prc_pkg::OBJ_W-1:0] time_mem [POP_SIZE];
  logic signed [prc_pkg::OBJ_W-1:0] mem_mem  [POP_SIZE];
  logic [prc_pkg::LV_W-1:0]         lvl_mem  [POP_SIZE];

  logic signed [prc_pkg::OBJ_W-1:0] rd_t_r, rd_m_r;
  logic [prc_pkg::LV_W-1:0]         rd_l_r;

  logic [POP_SIZE-1:0] done_r, new_r;

  // point p and search accumulators
  logic signed [prc_pkg::OBJ_W-1:0] pt_r, pm_r;
  logic [prc_pkg::LV_W-1:0]         pl_r;
  logic                             blocked_r;
  logic signed [prc_pkg::OBJ_W-1:0] tpred_r, tsucc_r, tmin_r, tmax_r;
  logic signed [prc_pkg::OBJ_W-1:0] mpred_r, msucc_r, mmin_r, mmax_r;
  logic signed [prc_pkg::OBJ_W-1:0] mpt_r, mst_r;
  logic tp_ok_r, ts_ok_r, mp_ok_r, ms_ok_r;
  logic [prc_pkg::DIST_W-1:0] tc_r;

  logic [IDX_W-1:0] j_ix, p_ix;
  logic             dominates, t_before, m_before, same_front;
  logic             t_edge, m_edge;
  logic signed [prc_pkg::OBJ_W:0] t_gap_w, t_rng_w, m_gap_w, m_rng_w;
  logic [prc_pkg::OBJ_W-1:0]      div_gap, div_rng;
  logic                           div_busy;
  logic [prc_pkg::Q_W-1:0]        quot;
  logic [prc_pkg::DIST_W:0]       dist_sum;
  logic [prc_pkg::DIST_W-1:0]     dist_val;

  prc_pkg::out_item_t out_r;
  logic               out_valid_r;

  assign j_ix = cmd.rd_addr[IDX_W-1:0];
  assign p_ix = cmd.p_idx[IDX_W-1:0];

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      time_mem[cmd.wr_addr[IDX_W-1:0]] <= in_data.time_delta;
      mem_mem[cmd.wr_addr[IDX_W-1:0]]  <= in_data.memory_delta;
    end
    if (cmd.assign_lvl) begin
      lvl_mem[p_ix] <= cmd.level;
    end
    rd_t_r <= time_mem[j_ix];
    rd_m_r <= mem_mem[j_ix];
    rd_l_r <= lvl_mem[j_ix];
  end

  // ranked set: done holds earlier fronts, new holds this pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      new_r  <= '0;
    end else if (cmd.clr_run) begin
      done_r <= '0;
      new_r  <= '0;
    end else if (cmd.end_pass) begin
      done_r <= done_r | new_r;
      new_r  <= '0;
    end else if (cmd.assign_lvl) begin
      new_r[p_ix] <= 1'b1;
    end
  end

  // comparisons of j (read data) against p
  assign dominates  = (rd_t_r <= pt_r) && (rd_m_r <= pm_r)
                      && !((rd_t_r == pt_r) && (rd_m_r == pm_r));
  assign t_before   = (rd_t_r < pt_r) || ((rd_t_r == pt_r) && (j_ix < p_ix));
  assign m_before   = (rd_m_r > pm_r) || ((rd_m_r == pm_r) && t_before);
  assign same_front = (rd_l_r == pl_r) && (j_ix != p_ix);

  // neighbour search in time order and in memory order
  always_ff @(posedge clk) begin
    if (cmd.latch_p) begin
      pt_r      <= rd_t_r;
      pm_r      <= rd_m_r;
      pl_r      <= rd_l_r;
      blocked_r <= 1'b0;
      tp_ok_r   <= 1'b0;
      ts_ok_r   <= 1'b0;
      mp_ok_r   <= 1'b0;
      ms_ok_r   <= 1'b0;
      tmin_r    <= rd_t_r;
      tmax_r    <= rd_t_r;
      mmin_r    <= rd_m_r;
      mmax_r    <= rd_m_r;
    end else if (cmd.rank_eval) begin
      if (dominates && !done_r[j_ix]) begin
        blocked_r <= 1'b1;
      end
    end else if (cmd.crowd_eval && same_front) begin
      if (t_before) begin
        if (!tp_ok_r || rd_t_r >= tpred_r) begin
          tpred_r <= rd_t_r;
          tp_ok_r <= 1'b1;
        end
      end else if (!ts_ok_r || rd_t_r < tsucc_r) begin
        tsucc_r <= rd_t_r;
        ts_ok_r <= 1'b1;
      end
      if (m_before) begin
        if (!mp_ok_r || rd_m_r < mpred_r || (rd_m_r == mpred_r && rd_t_r >= mpt_r)) begin
          mpred_r <= rd_m_r;
          mpt_r   <= rd_t_r;
          mp_ok_r <= 1'b1;
        end
      end else if (!ms_ok_r || rd_m_r > msucc_r || (rd_m_r == msucc_r && rd_t_r < mst_r)) begin
        msucc_r <= rd_m_r;
        mst_r   <= rd_t_r;
        ms_ok_r <= 1'b1;
      end
      if (rd_t_r < tmin_r) tmin_r <= rd_t_r;
      if (rd_t_r > tmax_r) tmax_r <= rd_t_r;
      if (rd_m_r < mmin_r) mmin_r <= rd_m_r;
      if (rd_m_r > mmax_r) mmax_r <= rd_m_r;
    end
  end

  // gaps and ranges, never negative once both neighbours are found
  assign t_gap_w = {tsucc_r[prc_pkg::OBJ_W-1], tsucc_r} - {tpred_r[prc_pkg::OBJ_W-1], tpred_r};
  assign t_rng_w = {tmax_r[prc_pkg::OBJ_W-1], tmax_r} - {tmin_r[prc_pkg::OBJ_W-1], tmin_r};
  assign m_gap_w = {mpred_r[prc_pkg::OBJ_W-1], mpred_r} - {msucc_r[prc_pkg::OBJ_W-1], msucc_r};
  assign m_rng_w = {mmax_r[prc_pkg::OBJ_W-1], mmax_r} - {mmin_r[prc_pkg::OBJ_W-1], mmin_r};

  assign div_gap = cmd.div_sel ? m_gap_w[prc_pkg::OBJ_W-1:0] : t_gap_w[prc_pkg::OBJ_W-1:0];
  assign div_rng = cmd.div_sel ? m_rng_w[prc_pkg::OBJ_W-1:0] : t_rng_w[prc_pkg::OBJ_W-1:0];

  prc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .gap   (div_gap),
    .range (div_rng),
    .busy  (div_busy),
    .quot  (quot)
  );

  // boundary or flat objective gives the fixed value 100
  assign t_edge = !tp_ok_r || !ts_ok_r || (tmax_r == tmin_r);
  assign m_edge = !mp_ok_r || !ms_ok_r || (mmax_r == mmin_r);

  always_ff @(posedge clk) begin
    if (cmd.take_t) begin
      tc_r <= t_edge ? prc_pkg::HUNDRED : prc_pkg::DIST_W'(quot);
    end
  end

  assign dist_sum = {1'b0, tc_r} + (prc_pkg::DIST_W + 1)'(quot);
  assign dist_val = m_edge ? prc_pkg::HUNDRED
                  : (dist_sum[prc_pkg::DIST_W] ? prc_pkg::DIST_MAX
                                               : dist_sum[prc_pkg::DIST_W-1:0]);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.point_index    <= cmd.p_idx;
      out_r.pareto_level   <= pl_r;
      out_r.crowd_distance <= dist_val;
      out_r.dropped_points <= cmd.dropped;
      out_r.last_result    <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.done_p   = done_r[p_ix];
  assign sts.blocked  = blocked_r;
  assign sts.div_busy = div_busy;
  assign sts.out_full = out_valid_r && !out_ready;

endmodule

// ===== hw/rtl/prc_ctrl.sv =====
// ----------------------------------------------------------------------------
// prc_ctrl
// Controller: load count, front peeling passes and per-point crowding steps.
// ----------------------------------------------------------------------------
module prc_ctrl #(
  parameter int POP_SIZE = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  prc_pkg::sts_t  sts,
  output prc_pkg::cmd_t  cmd
);

  localparam int IDX_W = $clog2(POP_SIZE);
  localparam int CNT_W = $clog2(POP_SIZE + 1);

  prc_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        left_r, left_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [IDX_W-1:0]        i_r, i_nxt, j_r, j_nxt;
  logic [prc_pkg::LV_W-1:0] lvl_r, lvl_nxt;
  logic                    last_i, last_j, full;

  assign last_i = (CNT_W'(i_r) + CNT_W'(1)) == count_r;
  assign last_j = (CNT_W'(j_r) + CNT_W'(1)) == count_r;
  assign full   = count_r == CNT_W'(POP_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prc_pkg::S_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    lvl_r  <= lvl_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    left_nxt  = left_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lvl_nxt   = lvl_r;
    in_ready  = 1'b0;
    cmd         = '0;
    cmd.wr_addr = prc_pkg::IX_W'(count_r);
    cmd.rd_addr = prc_pkg::IX_W'(i_r);
    cmd.p_idx   = prc_pkg::IX_W'(i_r);
    cmd.level   = lvl_r;
    cmd.dropped = ovf_r;
    cmd.last    = last_i;
    unique case (state_r)
      prc_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!full) begin
            cmd.wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            cmd.clr_run = 1'b1;
            lvl_nxt     = prc_pkg::LV_W'(1);
            left_nxt    = count_nxt;
            i_nxt       = '0;
            state_nxt   = prc_pkg::S_RK_I_RD;
          end
        end
      end
      // front peeling: p joins this front if no unranked point beats it
      prc_pkg::S_RK_I_RD: begin
        if (sts.done_p) begin
          if (last_i) begin
            state_nxt = prc_pkg::S_RK_END;
          end else begin
            i_nxt = i_r + IDX_W'(1);
          end
        end else begin
          state_nxt = prc_pkg::S_RK_I_LAT;
        end
      end
      prc_pkg::S_RK_I_LAT: begin
        cmd.latch_p = 1'b1;
        j_nxt       = '0;
        state_nxt   = prc_pkg::S_RK_J_RD;
      end
      prc_pkg::S_RK_J_RD: begin
        cmd.rd_addr = prc_pkg::IX_W'(j_r);
        state_nxt   = prc_pkg::S_RK_J_EV;
      end
      prc_pkg::S_RK_J_EV: begin
        cmd.rd_addr   = prc_pkg::IX_W'(j_r);
        cmd.rank_eval = 1'b1;
        if (last_j) begin
          state_nxt = prc_pkg::S_RK_ASSIGN;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = prc_pkg::S_RK_J_RD;
        end
      end
      prc_pkg::S_RK_ASSIGN: begin
        if (!sts.blocked) begin
          cmd.assign_lvl = 1'b1;
          left_nxt       = left_r - CNT_W'(1);
        end
        if (last_i) begin
          state_nxt = prc_pkg::S_RK_END;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = prc_pkg::S_RK_I_RD;
        end
      end
      prc_pkg::S_RK_END: begin
        cmd.end_pass = 1'b1;
        lvl_nxt      = lvl_r + prc_pkg::LV_W'(1);
        i_nxt        = '0;
        state_nxt    = (left_r == '0) ? prc_pkg::S_CR_P_RD : prc_pkg::S_RK_I_RD;
      end
      // crowding: neighbours of p inside its front, in load order of p
      prc_pkg::S_CR_P_RD: begin
        state_nxt = prc_pkg::S_CR_P_LAT;
      end
      prc_pkg::S_CR_P_LAT: begin
        cmd.latch_p = 1'b1;
        j_nxt       = '0;
        state_nxt   = prc_pkg::S_CR_J_RD;
      end
      prc_pkg::S_CR_J_RD: begin
        cmd.rd_addr = prc_pkg::IX_W'(j_r);
        state_nxt   = prc_pkg::S_CR_J_EV;
      end
      prc_pkg::S_CR_J_EV: begin
        cmd.rd_addr    = prc_pkg::IX_W'(j_r);
        cmd.crowd_eval = 1'b1;
        if (last_j) begin
          state_nxt = prc_pkg::S_TDIV;
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = prc_pkg::S_CR_J_RD;
        end
      end
      prc_pkg::S_TDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = prc_pkg::S_TDIV_W;
      end
      prc_pkg::S_TDIV_W: begin
        if (!sts.div_busy) begin
          cmd.take_t = 1'b1;
          state_nxt  = prc_pkg::S_MDIV;
        end
      end
      prc_pkg::S_MDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_nxt     = prc_pkg::S_MDIV_W;
      end
      prc_pkg::S_MDIV_W: begin
        cmd.div_sel = 1'b1;
        if (!sts.div_busy) begin
          state_nxt = prc_pkg::S_EMIT;
        end
      end
      prc_pkg::S_EMIT: begin
        cmd.div_sel = 1'b1;
        if (!sts.out_full) begin
          cmd.emit = 1'b1;
          if (last_i) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = prc_pkg::S_LOAD;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = prc_pkg::S_CR_P_RD;
          end
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/prc_checker.sv =====
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks on the Pareto rank and crowding block.
// ----------------------------------------------------------------------------
`include "pareto_rank_crowding_defines.svh"

module prc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input prc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input prc_pkg::out_item_t out_data
);

  // stalled result holds
  `PRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed under stall")

  // closing request starts ranking, no further load
  `PRC_ASSERT_NEXT(a_rank_start, in_valid && in_ready && in_data.last_point, !in_ready, "load open after last point")

  // a run in progress takes no requests
  `PRC_ASSERT(a_run_busy, (out_valid && !out_data.last_result) |-> !in_ready, "load open mid run")

  // front number from 1, distance within 100 plus one full gap
  `PRC_ASSERT(a_result_range, out_valid |-> (out_data.pareto_level != 0) && (out_data.crowd_distance <= 16'd25856), "result out of range")

endmodule

bind pareto_rank_crowding prc_checker u_prc_checker (.*);
